### sv/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants and types for the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int BB3_MAX_WIDTH = 1024;
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 12;
    localparam int ROW_BITS      = 13;   // input row runs to height + 1 while draining
    localparam int PIX_BITS      = 24;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // floor(y / 3) = (y * RECIP3) >> SH3 and floor(y / 9) = (y * RECIP9) >> SH9, y < 8192
    localparam logic [12:0] RECIP3 = 13'd5462;
    localparam int          SH3    = 14;
    localparam logic [12:0] RECIP9 = 13'd3641;
    localparam int          SH9    = 15;

    // window entry r*3+c, r: top/mid/bottom, c: left/mid/right; pixel is {red, green, blue}
    typedef logic [8:0][PIX_BITS-1:0] win_t;

    typedef struct packed {
        logic       en;
        logic       last;
        logic [8:0] mask;
    } sum_ctl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } mean_res_t;

endpackage

### sv/bb3_line_mem.sv
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store: one synchronous RAM holding {far row, near row} per column.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 48
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bb3_mean.sv
// ----------------------------------------------------------------------------
// bb3_mean
// Masked window sums (registered), then rounded mean by shift or reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_mean (
    input  logic              aclk,
    input  bb3_pkg::win_t     win,
    input  bb3_pkg::sum_ctl_t ctl,
    output bb3_pkg::mean_res_t res
);
    import bb3_pkg::*;

    logic [2:0][11:0] sum_next;
    logic [2:0][11:0] sum_reg;
    logic [3:0]       n_reg;
    logic             last_reg;

    // (2*s + n) / (2*n), worked per neighbour count
    function automatic logic [7:0] mean_div(input logic [11:0] s, input logic [3:0] n);
        logic [12:0] y;
        logic [12:0] m;
        logic [25:0] p;
        logic        use_mul;
        logic        by9;
        y       = 13'(s);
        m       = RECIP3;
        use_mul = 1'b0;
        by9     = 1'b0;
        case (n)
            4'd2: y = (13'(s) + 13'd1) >> 1;
            4'd3: begin
                y       = 13'(s) + 13'd1;
                use_mul = 1'b1;
            end
            4'd4: y = (13'(s) + 13'd2) >> 2;
            4'd6: begin
                y       = (13'(s) + 13'd3) >> 1;
                use_mul = 1'b1;
            end
            4'd9: begin
                y       = 13'(s) + 13'd4;
                m       = RECIP9;
                use_mul = 1'b1;
                by9     = 1'b1;
            end
            default: y = 13'(s);
        endcase
        p = 26'(y) * 26'(m);
        if (!use_mul) begin
            mean_div = y[7:0];
        end else if (by9) begin
            mean_div = 8'(p >> SH9);
        end else begin
            mean_div = 8'(p >> SH3);
        end
    endfunction

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < 9; i++) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (ctl.mask[i]) begin
                    sum_next[ch] = sum_next[ch] + 12'(win[i][8*ch +: 8]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            sum_reg  <= sum_next;
            n_reg    <= 4'($countones(ctl.mask));
            last_reg <= ctl.last;
        end
    end

    assign res.blue  = mean_div(sum_reg[0], n_reg);
    assign res.green = mean_div(sum_reg[1], n_reg);
    assign res.red   = mean_div(sum_reg[2], n_reg);
    assign res.last  = last_reg;

endmodule

### sv/box_blur_3x3_edge_aware_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// Streaming 3x3 box blur over RGB888 with edge-aware neighbour counts.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | contents
//  s_       | in  | s_tvalid/s_tready  | tdata {blue,green,red}, tuser mode (1 = drain)
//  m_       | out | m_tvalid/m_tready  | tdata {blue,green,red}, tlast frame_end
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index 0 width, 1 height; cfg_data
//
// A pixel or drain beat that yields a result passes these steps in order: accept, line
// store read/update, window sum, divide and load of the output register. One that yields
// no result skips the output step. The registered RAM read, issued on accept, feeds the
// read/update step. Ignored beats (pixel while draining, drain mid-frame) give nothing.
// The output register lets the next beat in while a result waits; a result that is
// not taken stalls the block in its final step. Reset and config writes restart the
// frame; line store contents need no clearing.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH = bb3_pkg::BB3_MAX_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red_in, green_in, blue_in
    input  logic        s_tuser,    // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // red_out, green_out, blue_out
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    import bb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SUM, ST_EMIT} state_t;

    state_t state_reg;

    logic [CFG_W_BITS-1:0] cfg_w_reg;
    logic [CFG_H_BITS-1:0] cfg_h_reg;
    logic [WW-1:0]         eff_w;
    logic [CFG_H_BITS-1:0] eff_h;

    logic [AW-1:0]         in_col_reg,  in_col_next;
    logic [ROW_BITS-1:0]   in_row_reg,  in_row_next;
    logic [AW-1:0]         out_col_reg, out_col_next;
    logic [CFG_H_BITS-1:0] out_row_reg, out_row_next;
    logic                  complete_reg, complete_next;

    logic [PIX_BITS-1:0]   pix_reg;
    logic                  drain_reg;
    logic                  emit_reg;
    logic                  last_reg;
    logic [AW-1:0]         ocol_reg;
    logic [CFG_H_BITS-1:0] orow_reg;
    win_t                  win_reg;

    logic [2*PIX_BITS-1:0] rd_data;
    logic [PIX_BITS-1:0]   far_px, near_px;
    logic                  take, cfg_wr, emit, last;
    logic                  out_load;
    logic [WW-1:0]         col_inc, oc_inc;
    logic                  col_wrap;
    logic [2:0]            row_ok, col_ok;
    sum_ctl_t              ctl;
    mean_res_t             res;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign take      = s_tvalid & s_tready & (s_tuser == complete_reg);

    always_comb begin
        if (cfg_w_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(cfg_w_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_w_reg);
        end
        eff_h = (cfg_h_reg == '0) ? CFG_H_BITS'(1) : cfg_h_reg;
    end

    assign far_px  = rd_data[2*PIX_BITS-1:PIX_BITS];
    assign near_px = rd_data[PIX_BITS-1:0];

    bb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2*PIX_BITS)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (in_col_reg),
        .wr_data ({near_px, pix_reg})
    );

    // counter update for the beat in the read step
    always_comb begin
        col_inc  = WW'(in_col_reg) + WW'(1);
        col_wrap = (col_inc >= eff_w);
        emit     = (in_row_reg >= ROW_BITS'(2)) || (in_row_reg == ROW_BITS'(1) && in_col_reg != '0);
        oc_inc   = WW'(out_col_reg) + WW'(1);
        last     = ((ROW_BITS'(out_row_reg) + ROW_BITS'(1)) >= ROW_BITS'(eff_h)) && (oc_inc >= eff_w);

        in_col_next   = col_wrap ? '0 : col_inc[AW-1:0];
        in_row_next   = col_wrap ? in_row_reg + ROW_BITS'(1) : in_row_reg;
        complete_next = complete_reg |
                        (!drain_reg && col_wrap && in_row_next >= ROW_BITS'(eff_h));
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        if (emit) begin
            if (last) begin
                in_col_next   = '0;
                in_row_next   = '0;
                complete_next = 1'b0;
                out_col_next  = '0;
                out_row_next  = '0;
            end else if (oc_inc >= eff_w) begin
                out_col_next = '0;
                out_row_next = out_row_reg + CFG_H_BITS'(1);
            end else begin
                out_col_next = oc_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg    <= CFG_W_BITS'(1024);
            cfg_h_reg    <= CFG_H_BITS'(768);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            complete_reg <= 1'b0;
        end else if (cfg_wr) begin
            if (cfg_index == CFG_IDX_WIDTH) begin
                cfg_w_reg <= cfg_data[CFG_W_BITS-1:0];
            end else begin
                cfg_h_reg <= cfg_data;
            end
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            complete_reg <= 1'b0;
        end else if (state_reg == ST_READ) begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            complete_reg <= complete_next;
        end
    end

    // beat payload and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (state_reg == ST_READ) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= far_px;
            win_reg[5] <= near_px;
            win_reg[8] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            drain_reg <= s_tuser;
            pix_reg   <= (s_tuser == MODE_DRAIN) ? '0
                                                 : {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end
        if (state_reg == ST_READ) begin
            emit_reg <= emit;
            last_reg <= last;
            ocol_reg <= out_col_reg;
            orow_reg <= out_row_reg;
        end
    end

    // in-bounds neighbours of the result position
    always_comb begin
        row_ok[0] = (orow_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (ROW_BITS'(orow_reg) + ROW_BITS'(1)) < ROW_BITS'(eff_h);
        col_ok[0] = (ocol_reg != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (WW'(ocol_reg) + WW'(1)) < eff_w;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ctl.mask[r*3 + c] = row_ok[r] & col_ok[c];
            end
        end
        ctl.en   = (state_reg == ST_SUM) && emit_reg;
        ctl.last = last_reg;
    end

    bb3_mean u_mean (
        .aclk (aclk),
        .win  (win_reg),
        .ctl  (ctl),
        .res  (res)
    );

    // output register may reload in the cycle its beat is taken
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_tvalid  <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid <= 1'b1;
                m_tdata  <= {res.blue, res.green, res.red};
                m_tlast  <= res.last;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_SUM;
                ST_SUM:  state_reg <= emit_reg ? ST_EMIT : ST_IDLE;
                ST_EMIT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

### sv/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks on the blur top level, attached by bind.
// ----------------------------------------------------------------------------
module bb3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // the input side reopens as soon as a result is loaded
    a_reopen_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("input side still closed after result load");

    // a new result only appears out of the final step, never straight from idle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while input side was open");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind box_blur_3x3_edge_aware_top bb3_checker u_bb3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 edge-aware box blur. Frames of random size
// are streamed with random pixels, stray drains and stray pixels; a predictor
// of the line stores, window and counters works out every blurred pixel, and
// the monitor compares them in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import bb3_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE = 12;

    typedef struct {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_beat_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_px_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [11:0] cfg_data;

    box_blur_3x3_edge_aware_top u_top (.*);

    pix_beat_t pending_beats[$];
    blur_px_t  blurred_due[$];
    pix_beat_t beat_on_bus;
    int        errors;
    int        quiet_cycles;
    int        send_gap;
    int        take_stall;
    bit        idle_on;
    int        items_sent;

    // predictor state
    logic [10:0]         width_reg;
    logic [11:0]         height_reg;
    logic [PIX_BITS-1:0] row_near[BB3_MAX_WIDTH];
    logic [PIX_BITS-1:0] row_far[BB3_MAX_WIDTH];
    logic [PIX_BITS-1:0] win[3][3];
    int                  in_col, in_row, out_col, out_row;
    bit                  frame_in;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > BB3_MAX_WIDTH) return BB3_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_in = 0;
    endfunction

    function automatic void blur_step(pix_beat_t b);
        int w, h, col, n, sr, sg, sb, rr, cc;
        bit drain, emit, last;
        logic [23:0] px, p;
        blur_px_t res;
        w = eff_w();
        h = eff_h();
        drain = (b.mode == MODE_DRAIN);
        if (drain != frame_in) return;
        px = drain ? 24'h0 : {b.red, b.green, b.blue};
        col = (in_col >= BB3_MAX_WIDTH) ? 0 : in_col;
        for (rr = 0; rr < 3; rr++) begin
            win[rr][0] = win[rr][1];
            win[rr][1] = win[rr][2];
        end
        win[0][2] = row_far[col];
        win[1][2] = row_near[col];
        win[2][2] = px;
        row_far[col] = row_near[col];
        row_near[col] = px;
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        in_col = col + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!drain && in_row >= h && in_col == 0) frame_in = 1;
        if (!emit) return;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (rr = -1; rr <= 1; rr++) begin
            if (out_row + rr < 0 || out_row + rr >= h) continue;
            for (cc = -1; cc <= 1; cc++) begin
                if (out_col + cc < 0 || out_col + cc >= w) continue;
                p = win[rr+1][cc+1];
                sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
                n++;
            end
        end
        if (n == 0) n = 1;
        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        res.red   = 8'((2*sr + n) / (2*n));
        res.green = 8'((2*sg + n) / (2*n));
        res.blue  = 8'((2*sb + n) / (2*n));
        res.last  = last;
        blurred_due.push_back(res);
        if (last) restart_frame();
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) blur_step(beat_on_bus);
            if (s_tvalid && !s_tready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                beat_on_bus = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= beat_on_bus.mode;
                s_tdata  <= {beat_on_bus.blue, beat_on_bus.green, beat_on_bus.red};
                send_gap = idle_on ? $urandom_range(0, 16) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        blur_px_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            take_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (blurred_due.size() == 0) begin
                    $display("unexpected result beat %h", m_tdata);
                    errors++;
                end else begin
                    want = blurred_due.pop_front();
                    if (m_tdata[7:0] !== want.red)    report("red", m_tdata[7:0], want.red);
                    if (m_tdata[15:8] !== want.green) report("green", m_tdata[15:8], want.green);
                    if (m_tdata[23:16] !== want.blue) report("blue", m_tdata[23:16], want.blue);
                    if (m_tlast !== want.last)        report("frame_end", m_tlast, want.last);
                end
                take_stall = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (take_stall > 0) begin
                take_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_beats.size() > 0 || s_tvalid || blurred_due.size() > 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == CFG_IDX_WIDTH) width_reg = val[10:0];
        else height_reg = val;
        restart_frame();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_beat(logic mode, logic [23:0] rgb);
        pix_beat_t b;
        b.mode = mode;
        b.red = rgb[7:0]; b.green = rgb[15:8]; b.blue = rgb[23:16];
        pending_beats.push_back(b);
        items_sent++;
    endtask

    // a frame with optional noise; npix below w*h leaves it unfinished
    task automatic queue_frame(int w, int h, int npix, bit noisy);
        int k;
        for (k = 0; k < npix; k++) begin
            if (noisy && $urandom_range(0, 19) == 0) push_beat(MODE_DRAIN, $urandom);
            push_beat(MODE_PIXEL, $urandom);
        end
        if (npix < w * h) return;
        for (k = 0; k < w + 1; k++) begin
            if (noisy && $urandom_range(0, 14) == 0) push_beat(MODE_PIXEL, $urandom);
            push_beat(MODE_DRAIN, $urandom);
        end
        if (noisy && $urandom_range(0, 3) == 0) push_beat(MODE_DRAIN, $urandom);
    endtask

    task automatic run_phase(int w, int h, int npix, bit noisy);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_IDX_WIDTH, 12'(w));
            write_reg(CFG_IDX_HEIGHT, 12'(h));
        end else begin
            write_reg(CFG_IDX_HEIGHT, 12'(h));
            write_reg(CFG_IDX_WIDTH, 12'(w));
        end
        queue_frame(w, h, npix, noisy);
        wait_idle();
    endtask

    initial begin
        int w, h, i;
        errors = 0;
        items_sent = 0;
        idle_on = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = MODE_PIXEL;
        m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = CFG_IDX_WIDTH; cfg_data = '0;
        quiet_cycles = 0;
        width_reg = 11'd1024;
        height_reg = 12'd768;
        restart_frame();
        for (i = 0; i < BB3_MAX_WIDTH; i++) begin
            row_near[i] = '0;
            row_far[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i/3][i%3] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme pixels, stray drain, pixel while draining, late drain
        write_reg(CFG_IDX_WIDTH, 12'd3);
        write_reg(CFG_IDX_HEIGHT, 12'd3);
        push_beat(MODE_DRAIN, 24'h0);
        for (i = 0; i < 9; i++) push_beat(MODE_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
        push_beat(MODE_DRAIN, 24'h0);
        push_beat(MODE_PIXEL, 24'h123456);
        for (i = 0; i < 3; i++) push_beat(MODE_DRAIN, 24'h0);
        push_beat(MODE_DRAIN, 24'h0);
        wait_idle();
        run_phase(1, 1, 1, 0);
        run_phase(1, 4, 4, 0);
        run_phase(5, 1, 5, 0);
        // largest size, left unfinished
        run_phase(1024, 4095, 1030, 0);

        while (items_sent < 1400) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(13, 300);
                h = $urandom_range(1, 4095);
                run_phase(w, h, (w * h < w + 30) ? w * h : w + 30, 1);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                run_phase(w, h, w * h, $urandom_range(0, 2) == 0);
            end
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
sv/bb3_pkg.sv
sv/bb3_line_mem.sv
sv/bb3_mean.sv
sv/box_blur_3x3_edge_aware_top.sv
sv/bb3_checker.sv
test/testbench.sv
